>>> rtl/core/projection_run_segmenter_core_assert.svh
// ----------------------------------------------------------------------------
// Projection run segmenter assertion macros
// Shared concurrent assertion forms used by the segmenter core.
// ----------------------------------------------------------------------------
`ifndef PROJECTION_RUN_SEGMENTER_CORE_ASSERT_SVH
`define PROJECTION_RUN_SEGMENTER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/prs_pkg.sv
// ----------------------------------------------------------------------------
// Projection run segmenter package
// Result types, register indexes and fixed constants shared by the core.
// ----------------------------------------------------------------------------
package prs_pkg;

   localparam int SEG_START_W  = 12;
   localparam int SEG_LENGTH_W = 13;
   localparam int INK_SUM_W    = 24;
   localparam int MIN_GAP_W    = 13;
   localparam int CSR_INDEX_W  = 8;
   localparam int CSR_DATA_W   = 24;
   localparam int RSP_DATA_W   = 32;

   localparam logic [INK_SUM_W-1:0] INK_THRESHOLD_RESET = 24'd3690;
   localparam logic [MIN_GAP_W-1:0] MIN_GAP_RESET       = 13'd10;

   // Output queue geometry.
   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_LEVEL_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_INK_THRESHOLD = 8'd0,
      CSR_MIN_GAP       = 8'd1
   } csr_index_type;

   typedef logic [SEG_START_W-1:0]  seg_start_type;
   typedef logic [SEG_LENGTH_W-1:0] seg_length_type;

   typedef struct packed {
      seg_start_type  seg_start;
      seg_length_type seg_length;
      logic           seg_valid;
      logic           last_result;
   } result_type;

   // Up to two results produced by one column.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } emit_type;

endpackage

>>> rtl/core/prs_tracker.sv
// ----------------------------------------------------------------------------
// Projection run segmenter tracker
// Run and pending-segment state, updated once per accepted column.
// ----------------------------------------------------------------------------
module prs_tracker #(
   parameter int MAX_COLUMNS = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                item_valid,
   input  logic [prs_pkg::INK_SUM_W-1:0]       column_ink_sum,
   input  logic                                final_column,
   input  logic [prs_pkg::INK_SUM_W-1:0]       ink_threshold,
   input  logic [prs_pkg::MIN_GAP_W-1:0]       min_gap,
   output prs_pkg::emit_type                   emit
);

   localparam int IDX_W = $clog2(MAX_COLUMNS);
   localparam int LEN_W = $clog2(MAX_COLUMNS + 1);
   localparam int END_W = LEN_W + 1;
   localparam int CMP_W = ((END_W > prs_pkg::MIN_GAP_W) ? END_W : prs_pkg::MIN_GAP_W) + 1;

   logic [IDX_W-1:0] column_index_ff, column_index_in;
   logic             in_run_ff, in_run_in;
   logic [IDX_W-1:0] run_start_ff, run_start_in;
   logic [LEN_W-1:0] run_length_ff, run_length_in;
   logic             pending_valid_ff, pending_valid_in;
   logic [IDX_W-1:0] pending_start_ff, pending_start_in;
   logic [LEN_W-1:0] pending_length_ff, pending_length_in;

   always_comb begin
      logic                  ink;
      logic                  do_close;
      logic                  merge;
      logic [END_W-1:0]      pend_end;
      logic [END_W-1:0]      run_end;
      logic [END_W-1:0]      span_end;
      logic [END_W-1:0]      merged_len;
      logic [1:0]            n;
      prs_pkg::result_type   res;

      ink = column_ink_sum > ink_threshold;
      in_run_in         = in_run_ff;
      run_start_in      = run_start_ff;
      run_length_in     = run_length_ff;
      pending_valid_in  = pending_valid_ff;
      pending_start_in  = pending_start_ff;
      pending_length_in = pending_length_ff;
      emit = '0;
      res  = '0;
      n = 2'd0;

      if (ink) begin
         if (!in_run_ff) begin
            in_run_in     = 1'b1;
            run_start_in  = column_index_ff;
            run_length_in = LEN_W'(1);
         end else if (run_length_ff < LEN_W'(MAX_COLUMNS)) begin
            run_length_in = run_length_ff + LEN_W'(1);
         end
      end

      // At most one run closes per column: either ink stops, or the image ends inside a run.
      do_close = (!ink && in_run_ff) || (final_column && ink);

      pend_end = END_W'(pending_start_ff) + END_W'(pending_length_ff);
      run_end  = END_W'(run_start_in) + END_W'(run_length_in);
      // A gap below min_gap merges; an overlapping run counts as a negative gap.
      merge = pending_valid_ff &&
              ((CMP_W'(pend_end) + CMP_W'(min_gap)) > CMP_W'(run_start_in));
      span_end   = (run_end > pend_end) ? run_end : pend_end;
      merged_len = span_end - END_W'(pending_start_ff);
      if (merged_len > END_W'(MAX_COLUMNS)) begin
         merged_len = END_W'(MAX_COLUMNS);
      end

      if (do_close) begin
         in_run_in = 1'b0;
         if (merge) begin
            pending_length_in = LEN_W'(merged_len);
         end else begin
            if (pending_valid_ff) begin
               emit.first.seg_start   = prs_pkg::seg_start_type'(pending_start_ff);
               emit.first.seg_length  = prs_pkg::seg_length_type'(pending_length_ff);
               emit.first.seg_valid   = 1'b1;
               emit.first.last_result = 1'b0;
               n = 2'd1;
            end
            pending_valid_in  = 1'b1;
            pending_start_in  = run_start_in;
            pending_length_in = run_length_in;
         end
      end

      column_index_in = column_index_ff;
      if (final_column) begin
         res.seg_start   = pending_valid_in ?
                           prs_pkg::seg_start_type'(pending_start_in) : '0;
         res.seg_length  = pending_valid_in ?
                           prs_pkg::seg_length_type'(pending_length_in) : '0;
         res.seg_valid   = pending_valid_in;
         res.last_result = 1'b1;
         if (n == 2'd0) begin
            emit.first = res;
         end else begin
            emit.second = res;
         end
         n = n + 2'd1;
         column_index_in   = '0;
         in_run_in         = 1'b0;
         run_start_in      = '0;
         run_length_in     = '0;
         pending_valid_in  = 1'b0;
         pending_start_in  = '0;
         pending_length_in = '0;
      end else if (column_index_ff != IDX_W'(MAX_COLUMNS - 1)) begin
         column_index_in = column_index_ff + IDX_W'(1);
      end

      emit.count = item_valid ? n : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_index_ff   <= '0;
         in_run_ff         <= 1'b0;
         run_start_ff      <= '0;
         run_length_ff     <= '0;
         pending_valid_ff  <= 1'b0;
         pending_start_ff  <= '0;
         pending_length_ff <= '0;
      end else if (item_valid) begin
         column_index_ff   <= column_index_in;
         in_run_ff         <= in_run_in;
         run_start_ff      <= run_start_in;
         run_length_ff     <= run_length_in;
         pending_valid_ff  <= pending_valid_in;
         pending_start_ff  <= pending_start_in;
         pending_length_ff <= pending_length_in;
      end
   end

endmodule

>>> rtl/core/prs_queue.sv
// ----------------------------------------------------------------------------
// Projection run segmenter result queue
// Small register queue taking up to two results per cycle, one out per cycle when popped.
// ----------------------------------------------------------------------------
module prs_queue (
   input  logic                                 clock,
   input  logic                                 reset,
   input  prs_pkg::emit_type                    emit,
   input  logic                                 pop,
   output prs_pkg::result_type                  head,
   output logic                                 not_empty,
   output logic [prs_pkg::QUEUE_LEVEL_W-1:0]    level
);

   prs_pkg::result_type                 entry_ff [prs_pkg::QUEUE_DEPTH];
   logic [prs_pkg::QUEUE_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [prs_pkg::QUEUE_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [prs_pkg::QUEUE_LEVEL_W-1:0]   level_ff, level_in;
   logic                                do_pop;

   assign not_empty = (level_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];
   assign level     = level_ff;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + prs_pkg::QUEUE_PTR_W'(emit.count);
      rd_ptr_in = rd_ptr_ff + prs_pkg::QUEUE_PTR_W'(do_pop);
      level_in  = level_ff + prs_pkg::QUEUE_LEVEL_W'(emit.count)
                  - prs_pkg::QUEUE_LEVEL_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= emit.first;
      end
      if (emit.count == 2'd2) begin
         entry_ff[wr_ptr_ff + prs_pkg::QUEUE_PTR_W'(1)] <= emit.second;
      end
   end

endmodule

>>> rtl/core/projection_run_segmenter_core.sv
// ----------------------------------------------------------------------------
// Projection run segmenter core
// Finds ink runs in a column profile, merges close runs and emits segments.
// ----------------------------------------------------------------------------
// Usage: one column ink sum enters per req_ transfer, in column order, with
// req_tlast marking the final column of an image. A column is ink when its
// sum is above ink_threshold; runs closer than min_gap are merged into one
// segment. Each segment leaves as one rsp_ transfer (start and length in
// rsp_tdata, rsp_tuser set for a real segment). The final column always
// yields a transfer with rsp_tlast set, which carries the last segment or,
// when the image had no ink, rsp_tuser clear and zero data.
// Results of a column enter the registered result queue with its transfer.
// Throughput: one column per cycle while req_tready is high; only the final
// column can make two results, so the four-entry result queue is what limits
// the rate, and req_tready drops only when fewer than two queue entries are free.
// Reset: the registers return to ink_threshold 3690 and min_gap 10, the
// image state clears and the queue empties. A stalled receiver fills the
// queue, after which req_tready is held low; no result is lost or dropped.
// Configuration (csr_) is always ready and is to be written only while idle.
// ----------------------------------------------------------------------------
`include "projection_run_segmenter_core_assert.svh"

module projection_run_segmenter_core #(
   parameter int MAX_COLUMNS = 4096
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Column input channel.
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [prs_pkg::INK_SUM_W-1:0]         req_tdata,   // [23:0] column_ink_sum
   input  logic                                  req_tlast,   // final_column
   // Segment result channel.
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [prs_pkg::RSP_DATA_W-1:0]        rsp_tdata,   // [11:0] seg_start,
                                                              // [24:12] seg_length,
                                                              // [31:25] zero
   output logic                                  rsp_tuser,   // seg_valid
   output logic                                  rsp_tlast,   // last_result
   // Configuration write channel.
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [prs_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [prs_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   logic [prs_pkg::INK_SUM_W-1:0]     ink_threshold_ff;
   logic [prs_pkg::MIN_GAP_W-1:0]     min_gap_ff;
   logic                              req_xfer;
   logic                              rsp_xfer;
   prs_pkg::emit_type                 emit;
   prs_pkg::result_type               head;
   logic                              queue_not_empty;
   logic [prs_pkg::QUEUE_LEVEL_W-1:0] queue_level;

   // Configuration registers; indexes beyond the list are accepted and ignored.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ink_threshold_ff <= prs_pkg::INK_THRESHOLD_RESET;
         min_gap_ff       <= prs_pkg::MIN_GAP_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            prs_pkg::CSR_INK_THRESHOLD: ink_threshold_ff <= csr_wdata;
            prs_pkg::CSR_MIN_GAP:       min_gap_ff <= csr_wdata[prs_pkg::MIN_GAP_W-1:0];
            default: ;
         endcase
      end
   end

   // A column is taken only when the queue can hold both results it may make.
   assign req_tready = (queue_level <= prs_pkg::QUEUE_LEVEL_W'(prs_pkg::QUEUE_DEPTH - 2));
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_xfer   = rsp_tvalid && rsp_tready;

   prs_tracker #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_tracker (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (req_xfer),
      .column_ink_sum (req_tdata),
      .final_column   (req_tlast),
      .ink_threshold  (ink_threshold_ff),
      .min_gap        (min_gap_ff),
      .emit           (emit)
   );

   prs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .emit      (emit),
      .pop       (rsp_xfer),
      .head      (head),
      .not_empty (queue_not_empty),
      .level     (queue_level)
   );

   assign rsp_tvalid = queue_not_empty;
   assign rsp_tdata  = prs_pkg::RSP_DATA_W'({head.seg_length, head.seg_start});
   assign rsp_tuser  = head.seg_valid;
   assign rsp_tlast  = head.last_result;

   // The queue never holds more entries than it has.
   `PRS_ASSERT_SAME(a_queue_bound, clock, reset, 1'b1,
      queue_level <= prs_pkg::QUEUE_LEVEL_W'(prs_pkg::QUEUE_DEPTH),
      "result queue overflow")

   // Only the final column may produce two results.
   `PRS_ASSERT_SAME(a_two_only_on_final, clock, reset, req_xfer && !req_tlast,
      emit.count != 2'd2, "two results from a non-final column")

   // A final column always leaves a result waiting on the next cycle.
   `PRS_ASSERT_NEXT(a_final_has_result, clock, reset, req_xfer && req_tlast,
      rsp_tvalid, "final column produced no result")

   // A result without a segment carries zero start and length and closes the image.
   `PRS_ASSERT_SAME(a_empty_result_form, clock, reset, rsp_tvalid && !rsp_tuser,
      (rsp_tdata == '0) && rsp_tlast, "malformed empty result")

endmodule

>>> dv/projection_run_segmenter_checker.sv
// ----------------------------------------------------------------------------
// Projection run segmenter checker
// Watches the column, segment and register channels of the segmenter core,
// tracks the segments each column should produce and compares every segment
// transfer against the oldest one still due.
// ----------------------------------------------------------------------------
module projection_run_segmenter_checker
   import prs_pkg::*;
#(
   parameter int MAX_COLUMNS = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [INK_SUM_W-1:0]   req_tdata,   // [23:0] column_ink_sum
   input  logic                   req_tlast,   // final_column
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_DATA_W-1:0]  rsp_tdata,   // [11:0] seg_start, [24:12] seg_length
   input  logic                   rsp_tuser,   // seg_valid
   input  logic                   rsp_tlast,   // last_result
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     mismatches,
   output int                     awaiting
);

   localparam int LEN_LO = SEG_START_W;
   localparam int LEN_HI = SEG_START_W + SEG_LENGTH_W - 1;

   // Shadow registers and per-image state.
   logic [INK_SUM_W-1:0]    ink_floor;
   logic [MIN_GAP_W-1:0]    merge_gap;
   logic [SEG_START_W-1:0]  column_at;
   logic                    run_open;
   logic [SEG_START_W-1:0]  run_first;
   logic [SEG_LENGTH_W-1:0] run_width;
   logic                    held_valid;
   logic [SEG_START_W-1:0]  held_first;
   logic [SEG_LENGTH_W-1:0] held_width;

   result_type segments_due[$];

   task automatic post_segment(input logic [SEG_START_W-1:0] start,
                               input logic [SEG_LENGTH_W-1:0] width,
                               input logic valid, input logic last);
      result_type seg;
      seg.seg_start   = start;
      seg.seg_length  = width;
      seg.seg_valid   = valid;
      seg.last_result = last;
      segments_due.insert(segments_due.size(), seg);
   endtask

   task automatic clear_image();
      column_at  = '0;
      run_open   = 1'b0;
      run_first  = '0;
      run_width  = '0;
      held_valid = 1'b0;
      held_first = '0;
      held_width = '0;
   endtask

   // A finished run either joins the held segment or pushes it out.
   // The gap may come out negative once the column counter has saturated.
   task automatic close_ink_run();
      int held_end;
      int run_end;
      int gap;
      int span;
      run_open = 1'b0;
      if (held_valid) begin
         held_end = int'(held_first) + int'(held_width);
         run_end  = int'(run_first) + int'(run_width);
         gap      = int'(run_first) - held_end;
         if (gap < int'(merge_gap)) begin
            span = ((run_end > held_end) ? run_end : held_end) - int'(held_first);
            if (span > MAX_COLUMNS) span = MAX_COLUMNS;
            held_width = span[SEG_LENGTH_W-1:0];
            return;
         end
         post_segment(held_first, held_width, 1'b1, 1'b0);
      end
      held_valid = 1'b1;
      held_first = run_first;
      held_width = run_width;
   endtask

   task automatic advance_column(input logic [INK_SUM_W-1:0] sum, input logic fin);
      if (sum > ink_floor) begin
         if (!run_open) begin
            run_open  = 1'b1;
            run_first = column_at;
            run_width = SEG_LENGTH_W'(1);
         end else if (int'(run_width) < MAX_COLUMNS) begin
            run_width = run_width + 1'b1;
         end
      end else if (run_open) begin
         close_ink_run();
      end
      if (fin) begin
         if (run_open) close_ink_run();
         if (held_valid) post_segment(held_first, held_width, 1'b1, 1'b1);
         else post_segment('0, '0, 1'b0, 1'b1);
         clear_image();
      end else if (int'(column_at) < MAX_COLUMNS - 1) begin
         column_at = column_at + 1'b1;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         ink_floor = INK_THRESHOLD_RESET;
         merge_gap = MIN_GAP_RESET;
         clear_image();
         segments_due.delete();
         mismatches = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_INK_THRESHOLD) ink_floor = csr_wdata[INK_SUM_W-1:0];
            else if (csr_index == CSR_MIN_GAP) merge_gap = csr_wdata[MIN_GAP_W-1:0];
         end
         if (req_tvalid && req_tready) advance_column(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (segments_due.size() == 0) begin
               $error("unexpected segment transfer: seg_start %0d seg_length %0d %s %0d %s %0d",
                      rsp_tdata[SEG_START_W-1:0], rsp_tdata[LEN_HI:LEN_LO],
                      "seg_valid", rsp_tuser, "last_result", rsp_tlast);
               mismatches++;
            end else begin
               want = segments_due.pop_front();
               if (rsp_tdata[SEG_START_W-1:0] !== want.seg_start) begin
                  $error("seg_start: expected %0d, actual %0d",
                         want.seg_start, rsp_tdata[SEG_START_W-1:0]);
                  mismatches++;
               end
               if (rsp_tdata[LEN_HI:LEN_LO] !== want.seg_length) begin
                  $error("seg_length: expected %0d, actual %0d",
                         want.seg_length, rsp_tdata[LEN_HI:LEN_LO]);
                  mismatches++;
               end
               if (rsp_tdata[RSP_DATA_W-1:LEN_HI+1] !== '0) begin
                  $error("tdata padding: expected 0, actual %0h",
                         rsp_tdata[RSP_DATA_W-1:LEN_HI+1]);
                  mismatches++;
               end
               if (rsp_tuser !== want.seg_valid) begin
                  $error("seg_valid: expected %0d, actual %0d", want.seg_valid, rsp_tuser);
                  mismatches++;
               end
               if (rsp_tlast !== want.last_result) begin
                  $error("last_result: expected %0d, actual %0d",
                         want.last_result, rsp_tlast);
                  mismatches++;
               end
            end
         end
      end
      awaiting = segments_due.size();
   end

endmodule

>>> dv/projection_run_segmenter_core_tb.sv
// ----------------------------------------------------------------------------
// Projection run segmenter core testbench
// Streams column ink profiles into the segmenter core under several register
// settings, with random idle cycles on the column side and random stalls on
// the segment side, and leaves all checking to the segment checker.
// ----------------------------------------------------------------------------
module projection_run_segmenter_core_tb;
   import prs_pkg::*;

   localparam int COLUMNS = 4096;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [INK_SUM_W-1:0]   req_tdata;
   logic                   req_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // When steady is set neither side idles; otherwise both idle about a third
   // of the time.
   logic steady = 1'b0;

   // What the stimulus believes the registers hold, used only to aim column
   // sums around the threshold and gaps around min_gap.
   logic [INK_SUM_W-1:0] cur_thr = INK_THRESHOLD_RESET;
   logic [MIN_GAP_W-1:0] cur_gap = MIN_GAP_RESET;

   int mismatches;
   int awaiting;

   always #2 clock = ~clock;

   projection_run_segmenter_core #(
      .MAX_COLUMNS(COLUMNS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   projection_run_segmenter_checker #(
      .MAX_COLUMNS(COLUMNS)
   ) segment_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .awaiting   (awaiting)
   );

   // The receiver stalls at random, which backs results up into the core's
   // queue and eventually pulls req_tready low.
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= 33);
   end

   // A column sum that counts as ink under the current threshold. Most land
   // just above it; some anywhere up to full scale.
   function automatic logic [INK_SUM_W-1:0] ink_value();
      longint v;
      if (cur_thr == {INK_SUM_W{1'b1}}) return cur_thr;
      if ($urandom_range(0, 3) == 0) v = longint'($urandom_range(32'hFFFFFF, int'(cur_thr) + 1));
      else v = longint'(cur_thr) + 1 + longint'($urandom_range(0, 3000));
      if (v > 64'hFFFFFF) v = 64'hFFFFFF;
      return v[INK_SUM_W-1:0];
   endfunction

   // A column sum that is not ink; the threshold itself shows up often since
   // a sum equal to it must not count.
   function automatic logic [INK_SUM_W-1:0] dark_value();
      if ($urandom_range(0, 3) == 0) return cur_thr;
      return INK_SUM_W'($urandom_range(int'(cur_thr), 0));
   endfunction

   // One column transfer, preceded by random idle cycles. The ready is looked
   // at on the falling edge, where nothing is changing, and the transfer takes
   // place at the rising edge that follows.
   task automatic send_column(input logic [INK_SUM_W-1:0] sum, input logic fin);
      while (!steady && $urandom_range(0, 99) < 33) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sum;
      req_tlast  <= fin;
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
   endtask

   // One register write. Registers are only written once the core is idle.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      csr_valid <= 1'b0;
      if (index == CSR_INK_THRESHOLD) cur_thr = data[INK_SUM_W-1:0];
      else if (index == CSR_MIN_GAP) cur_gap = data[MIN_GAP_W-1:0];
      @(posedge clock);
   endtask

   // Drop valid and wait until every segment due has been transferred, then let
   // the clock run on in case the last column is still inside the core without
   // having produced anything.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (awaiting != 0) @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   // One image: alternating ink runs and dark gaps with random content. Gaps
   // are drawn around min_gap so that both merging and splitting happen. About
   // one column in eight is a full-range random sum as noise.
   task automatic send_image(input int ncols);
      int  left;
      int  gap_span;
      bit  ink;
      logic [INK_SUM_W-1:0] sum;
      gap_span = (int'(cur_gap) + 3 > 20) ? 20 : int'(cur_gap) + 3;
      ink  = 1'($urandom_range(0, 1));
      left = $urandom_range(1, 5);
      for (int i = 0; i < ncols; i++) begin
         if (left == 0) begin
            ink  = !ink;
            left = ink ? $urandom_range(1, 6) : $urandom_range(1, gap_span);
         end
         left--;
         if ($urandom_range(0, 7) == 0) sum = INK_SUM_W'($urandom());
         else sum = ink ? ink_value() : dark_value();
         send_column(sum, i == ncols - 1);
      end
   endtask

   // Whole images until roughly the given number of columns has gone in.
   // Single-column images come up now and then.
   task automatic send_images(input int budget);
      int sent;
      int n;
      sent = 0;
      while (sent < budget) begin
         n = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 30);
         send_image(n);
         sent += n;
      end
   endtask

   // Hard stop for a hung handshake.
   initial begin
      #2000000;
      $display("FAIL");
      $finish;
   end

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      csr_valid  <= 1'b0;
      csr_index  <= '0;
      csr_wdata  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed columns at the reset register values (threshold 3690,
      // min_gap 10). An image with no ink must still give a last result.
      send_column('0, 1'b1);
      // Ink only on the final column: a run of length 1 starting there. A sum
      // equal to the threshold is not ink.
      send_column(24'd3690, 1'b0);
      send_column(24'd3691, 1'b1);
      // A gap of 9 merges, a gap of exactly 10 does not, and the run on the
      // final column closes with the held segment still out, so that column
      // yields two results.
      send_column(24'hFFFFFF, 1'b0);
      repeat (9) send_column(dark_value(), 1'b0);
      send_column(ink_value(), 1'b0);
      repeat (10) send_column(dark_value(), 1'b0);
      send_column(ink_value(), 1'b1);
      settle();

      // Random images under a spread of settings. A write to an index past
      // the register list must be ignored.
      write_register(CSR_INK_THRESHOLD, CSR_DATA_W'($urandom_range(0, 20000)));
      write_register(CSR_MIN_GAP, '0);
      send_images(60);
      settle();

      write_register(CSR_INDEX_W'($urandom_range(255, 2)), CSR_DATA_W'($urandom()));
      write_register(CSR_INK_THRESHOLD, '0);
      write_register(CSR_MIN_GAP, CSR_DATA_W'($urandom_range(1, 12)));
      send_images(50);
      settle();

      // Nothing can be ink at full-scale threshold, so every image is empty.
      write_register(CSR_INK_THRESHOLD, 24'hFFFFFF);
      write_register(CSR_MIN_GAP, 24'd4096);
      send_images(40);
      settle();

      write_register(CSR_INK_THRESHOLD, CSR_DATA_W'($urandom_range(32'hFFFFFF, 0)));
      write_register(CSR_INDEX_W'($urandom_range(255, 2)), CSR_DATA_W'($urandom()));
      send_images(50);
      settle();

      // All ones on the write data: min_gap keeps only its low 13 bits.
      write_register(CSR_MIN_GAP, 24'hFFFFFF);
      write_register(CSR_INK_THRESHOLD, CSR_DATA_W'($urandom_range(0, 5000)));
      send_images(40);
      settle();

      // A long stretch with no idling on either side.
      steady = 1'b1;
      write_register(CSR_INK_THRESHOLD, CSR_DATA_W'($urandom_range(0, 100000)));
      write_register(CSR_MIN_GAP, CSR_DATA_W'($urandom_range(2, 12)));
      send_images(70);
      settle();
      steady = 1'b0;

      // A final short stretch back at mid settings.
      write_register(CSR_INK_THRESHOLD, CSR_DATA_W'($urandom_range(0, 20000)));
      write_register(CSR_MIN_GAP, CSR_DATA_W'($urandom_range(1, 10)));
      send_images(40);
      settle();

      repeat (8) @(posedge clock);
      if (mismatches == 0 && awaiting == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/prs_pkg.sv
rtl/core/prs_tracker.sv
rtl/core/prs_queue.sv
rtl/core/projection_run_segmenter_core.sv
dv/projection_run_segmenter_checker.sv
dv/projection_run_segmenter_core_tb.sv
